/* hdl/bmprgb_pkg.sv */
// bmprgb_pkg: shared types, codes and constants for the bmp to rgb565 stream converter
// no dependencies; used by bmprgb_hdr, bmprgb_walk and bmp_stream_to_rgb565
package bmprgb_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HDR_OK = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_SIGNATURE  = 3'd1,
        ERR_COMPRESSED = 3'd2,
        ERR_DEPTH      = 3'd3,
        ERR_SIZE       = 3'd4,
        ERR_OFFSET     = 3'd5,
        ERR_TRUNCATED  = 3'd6
    } t_err;

    localparam logic [15:0] BMP_MAGIC    = 16'h4D42;
    localparam logic [31:0] HDR_BYTES    = 32'd54;
    localparam logic [31:0] LAST_HDR_POS = 32'd53;
    localparam logic [15:0] DEPTH_24     = 16'd24;
    localparam logic [15:0] DEPTH_32     = 16'd32;
    localparam logic [7:0]  RED_MASK     = 8'hF8;
    localparam logic [7:0]  GREEN_MASK   = 8'hFC;
    localparam int          SIGN_BIT     = 31;

    // one result item
    typedef struct packed {
        t_kind       kind;
        logic [15:0] pix;
        logic [9:0]  col;
        logic [9:0]  row;
        logic [10:0] width;
        logic [10:0] height;
        t_err        err;
    } t_result;

    // header byte write from the parser to the header store
    typedef struct packed {
        logic       en;
        logic [5:0] pos;
        logic [7:0] data;
    } t_hdr_wr;

    // header check status, registered from the stored fields
    typedef struct packed {
        t_err err;
        logic bpp4;
        logic bottom_up;
        logic at_hdr_end;
    } t_hdr_stat;

    function automatic t_result res_info(t_kind kind, logic [10:0] width, logic [10:0] height);
        t_result res;
        res        = '0;
        res.kind   = kind;
        res.width  = width;
        res.height = height;
        res.err    = ERR_NONE;
        return res;
    endfunction

    function automatic t_result res_fail(t_err err);
        t_result res;
        res      = '0;
        res.kind = KIND_ERROR;
        res.err  = err;
        return res;
    endfunction

endpackage

/* hdl/bmprgb_hdr.sv */
// bmprgb_hdr: header field store and registered header check
// depends on bmprgb_pkg
module bmprgb_hdr #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bmprgb_pkg::t_hdr_wr                    i_wr,
    output bmprgb_pkg::t_hdr_stat                  o_stat,
    output logic [31:0]                            o_offset,
    output logic [$clog2(MAX_WIDTH+1)-1:0]         o_width,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]        o_height,
    output logic [$clog2(4*MAX_WIDTH+1)-1:0]       o_row_bytes
);

    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int HB  = $clog2(MAX_HEIGHT + 1);
    localparam int RBB = $clog2(4 * MAX_WIDTH + 1);

    localparam logic [5:0] BASE_SIG = 6'd0;
    localparam logic [5:0] BASE_OFF = 6'd10;
    localparam logic [5:0] BASE_WID = 6'd18;
    localparam logic [5:0] BASE_HGT = 6'd22;
    localparam logic [5:0] BASE_DEP = 6'd28;
    localparam logic [5:0] BASE_CMP = 6'd30;

    typedef enum logic [2:0] {
        F_NONE, F_SIG, F_OFF, F_WID, F_HGT, F_DEP, F_CMP
    } t_field;

    t_field      w_field;
    logic [5:0]  w_base;
    logic [1:0]  w_lane;

    logic [15:0] r_sig;
    logic [31:0] r_offset;
    logic [31:0] r_width;
    logic [31:0] r_height;
    logic [15:0] r_depth;
    logic [31:0] r_comp;

    logic [31:0]          w_abs;
    bmprgb_pkg::t_err     w_err;
    logic [WB-1:0]        w_wlo;
    logic [RBB-1:0]       w_rb3;
    logic [RBB-1:0]       w_rb;

    bmprgb_pkg::t_hdr_stat r_stat;
    logic [HB-1:0]         r_abs_h;
    logic [RBB-1:0]        r_row_bytes;

    // field decode by header position
    always_comb begin
        w_field = F_NONE;
        w_base  = BASE_SIG;
        case (i_wr.pos) inside
            [6'd0:6'd1]: begin
                w_field = F_SIG;
                w_base  = BASE_SIG;
            end
            [6'd10:6'd13]: begin
                w_field = F_OFF;
                w_base  = BASE_OFF;
            end
            [6'd18:6'd21]: begin
                w_field = F_WID;
                w_base  = BASE_WID;
            end
            [6'd22:6'd25]: begin
                w_field = F_HGT;
                w_base  = BASE_HGT;
            end
            [6'd28:6'd29]: begin
                w_field = F_DEP;
                w_base  = BASE_DEP;
            end
            [6'd30:6'd33]: begin
                w_field = F_CMP;
                w_base  = BASE_CMP;
            end
            default: begin
                w_field = F_NONE;
                w_base  = BASE_SIG;
            end
        endcase
        w_lane = 2'(i_wr.pos - w_base);
    end

    // little-endian field capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig    <= '0;
            r_offset <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_depth  <= '0;
            r_comp   <= '0;
        end else if (i_wr.en) begin
            case (w_field)
                F_SIG:   r_sig[{w_lane[0], 3'b000} +: 8]  <= i_wr.data;
                F_OFF:   r_offset[{w_lane, 3'b000} +: 8] <= i_wr.data;
                F_WID:   r_width[{w_lane, 3'b000} +: 8]  <= i_wr.data;
                F_HGT:   r_height[{w_lane, 3'b000} +: 8] <= i_wr.data;
                F_DEP:   r_depth[{w_lane[0], 3'b000} +: 8] <= i_wr.data;
                F_CMP:   r_comp[{w_lane, 3'b000} +: 8]   <= i_wr.data;
                default: ;
            endcase
        end
    end

    // checks in priority order, first failure wins
    always_comb begin
        w_abs = r_height[bmprgb_pkg::SIGN_BIT] ? (32'd0 - r_height) : r_height;
        if (r_sig != bmprgb_pkg::BMP_MAGIC) begin
            w_err = bmprgb_pkg::ERR_SIGNATURE;
        end else if (r_comp != 32'd0) begin
            w_err = bmprgb_pkg::ERR_COMPRESSED;
        end else if (r_depth != bmprgb_pkg::DEPTH_24 && r_depth != bmprgb_pkg::DEPTH_32) begin
            w_err = bmprgb_pkg::ERR_DEPTH;
        end else if (r_width == 32'd0 || r_width[bmprgb_pkg::SIGN_BIT]
                     || r_width > 32'(MAX_WIDTH)) begin
            w_err = bmprgb_pkg::ERR_SIZE;
        end else if (w_abs == 32'd0 || w_abs > 32'(MAX_HEIGHT)) begin
            w_err = bmprgb_pkg::ERR_SIZE;
        end else if (r_offset < bmprgb_pkg::HDR_BYTES) begin
            w_err = bmprgb_pkg::ERR_OFFSET;
        end else begin
            w_err = bmprgb_pkg::ERR_NONE;
        end
    end

    // padded row length: 4w, or 3w rounded up to a multiple of four
    always_comb begin
        w_wlo = r_width[WB-1:0];
        w_rb3 = RBB'({w_wlo, 1'b0}) + RBB'(w_wlo) + RBB'(3);
        if (r_depth == bmprgb_pkg::DEPTH_32) begin
            w_rb = RBB'({w_wlo, 2'b00});
        end else begin
            w_rb = {w_rb3[RBB-1:2], 2'b00};
        end
    end

    // fields settle long before the last header byte, so one register stage is free
    always_ff @(posedge i_clk) begin
        r_stat.err        <= w_err;
        r_stat.bpp4       <= (r_depth == bmprgb_pkg::DEPTH_32);
        r_stat.bottom_up  <= !r_height[bmprgb_pkg::SIGN_BIT];
        r_stat.at_hdr_end <= (r_offset == bmprgb_pkg::HDR_BYTES);
        r_abs_h           <= w_abs[HB-1:0];
        r_row_bytes       <= w_rb;
    end

    assign o_stat      = r_stat;
    assign o_offset    = r_offset;
    assign o_width     = w_wlo;
    assign o_height    = r_abs_h;
    assign o_row_bytes = r_row_bytes;

endmodule

/* hdl/bmprgb_walk.sv */
// bmprgb_walk: parse sequencer, pixel walk, rgb565 packing and one-deep held result
// depends on bmprgb_pkg; reads the header store in bmprgb_hdr
module bmprgb_walk #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_go,
    input  logic [7:0]                             i_byte,
    input  logic                                   i_first,
    input  logic                                   i_last,
    input  bmprgb_pkg::t_hdr_stat                  i_stat,
    input  logic [31:0]                            i_offset,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         i_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]        i_height,
    input  logic [$clog2(4*MAX_WIDTH+1)-1:0]       i_row_bytes,
    output bmprgb_pkg::t_hdr_wr                    o_wr,
    output logic                                   o_res_valid,
    output bmprgb_pkg::t_result                    o_res
);

    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int HB  = $clog2(MAX_HEIGHT + 1);
    localparam int RBB = $clog2(4 * MAX_WIDTH + 1);

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_SKIP   = 6'b000100,
        PH_PIXELS = 6'b001000,
        PH_DONE   = 6'b010000,
        PH_ERROR  = 6'b100000
    } t_phase;

    t_phase              r_phase, n_phase, w_phase;
    logic [31:0]         r_pos, n_pos, w_pos;
    logic [HB-1:0]       r_srow, n_srow, w_srow;
    logic [WB-1:0]       r_col, n_col, w_col;
    logic [1:0]          r_bip, n_bip, w_bip;
    logic [RBB-1:0]      r_bir, n_bir, w_bir;
    logic [7:0]          r_blue, n_blue;
    logic [7:0]          r_green, n_green;
    logic                r_held_v, n_held_v;
    bmprgb_pkg::t_result r_held, n_held;

    logic                m0_v, m1_v;
    bmprgb_pkg::t_result m0, m1, w_new;
    logic                w_do_pix;
    logic [7:0]          w_red_m, w_green_m;
    logic [HB-1:0]       w_out_row;
    logic [10:0]         w_w11, w_h11;

    always_comb begin
        // a first byte restarts the parse before this byte is handled
        w_phase = i_first ? PH_HEADER : r_phase;
        w_pos   = i_first ? 32'd0 : r_pos;
        w_srow  = i_first ? '0 : r_srow;
        w_col   = i_first ? '0 : r_col;
        w_bip   = i_first ? '0 : r_bip;
        w_bir   = i_first ? '0 : r_bir;

        w_w11     = 11'(i_width);
        w_h11     = 11'(i_height);
        w_red_m   = i_byte & bmprgb_pkg::RED_MASK;
        w_green_m = r_green & bmprgb_pkg::GREEN_MASK;
        w_out_row = i_stat.bottom_up ? (i_height - HB'(1) - w_srow) : w_srow;

        n_phase = w_phase;
        n_srow  = w_srow;
        n_col   = w_col;
        n_bip   = w_bip;
        n_bir   = w_bir;
        n_blue  = r_blue;
        n_green = r_green;
        m0_v    = 1'b0;
        m1_v    = 1'b0;
        m0      = '0;
        m1      = '0;
        w_new   = '0;

        w_do_pix = (w_phase == PH_PIXELS)
                   || (w_phase == PH_SKIP && w_pos == i_offset);

        if (w_phase == PH_HEADER) begin
            if (w_pos == bmprgb_pkg::LAST_HDR_POS) begin
                if (i_stat.err != bmprgb_pkg::ERR_NONE) begin
                    n_phase = PH_ERROR;
                    m0_v    = 1'b1;
                    m0      = bmprgb_pkg::res_fail(i_stat.err);
                end else begin
                    n_phase = i_stat.at_hdr_end ? PH_PIXELS : PH_SKIP;
                    m0_v    = 1'b1;
                    m0      = bmprgb_pkg::res_info(bmprgb_pkg::KIND_HDR_OK, w_w11, w_h11);
                    if (i_last) begin
                        n_phase = PH_ERROR;
                        m1_v    = 1'b1;
                        m1      = bmprgb_pkg::res_fail(bmprgb_pkg::ERR_TRUNCATED);
                    end
                end
            end else if (i_last) begin
                n_phase = PH_ERROR;
                m0_v    = 1'b1;
                m0      = bmprgb_pkg::res_fail(bmprgb_pkg::ERR_TRUNCATED);
            end
        end else if (w_do_pix) begin
            n_phase = PH_PIXELS;
            if (w_col < i_width) begin
                case (w_bip)
                    2'd0: n_blue = i_byte;
                    2'd1: n_green = i_byte;
                    2'd2: begin
                        m0_v   = 1'b1;
                        m0     = bmprgb_pkg::res_info(bmprgb_pkg::KIND_PIXEL, w_w11, w_h11);
                        m0.pix = {w_red_m[7:3], w_green_m[7:2], r_blue[7:3]};
                        m0.col = 10'(w_col);
                        m0.row = 10'(w_out_row);
                    end
                    default: ;
                endcase
                if (w_bip == (i_stat.bpp4 ? 2'd3 : 2'd2)) begin
                    n_bip = 2'd0;
                    n_col = w_col + WB'(1);
                end else begin
                    n_bip = w_bip + 2'd1;
                end
            end
            n_bir = w_bir + RBB'(1);
            if (n_bir >= i_row_bytes) begin
                // end of a stored row, padding included
                n_bir  = '0;
                n_col  = '0;
                n_bip  = 2'd0;
                n_srow = w_srow + HB'(1);
                if (n_srow >= i_height) begin
                    n_phase = PH_DONE;
                    w_new   = bmprgb_pkg::res_info(bmprgb_pkg::KIND_DONE, w_w11, w_h11);
                end else if (i_last) begin
                    n_phase = PH_ERROR;
                    w_new   = bmprgb_pkg::res_fail(bmprgb_pkg::ERR_TRUNCATED);
                end
            end else if (i_last) begin
                n_phase = PH_ERROR;
                w_new   = bmprgb_pkg::res_fail(bmprgb_pkg::ERR_TRUNCATED);
            end
            if (n_phase == PH_DONE || n_phase == PH_ERROR) begin
                if (m0_v) begin
                    m1_v = 1'b1;
                    m1   = w_new;
                end else begin
                    m0_v = 1'b1;
                    m0   = w_new;
                end
            end
        end else if (w_phase == PH_SKIP && i_last) begin
            n_phase = PH_ERROR;
            m0_v    = 1'b1;
            m0      = bmprgb_pkg::res_fail(bmprgb_pkg::ERR_TRUNCATED);
        end

        // byte position saturates
        if (n_phase != PH_IDLE && w_pos != 32'hFFFF_FFFF) begin
            n_pos = w_pos + 32'd1;
        end else begin
            n_pos = w_pos;
        end

        // a held result goes first, this byte's first result waits behind it
        if (r_held_v) begin
            n_held_v = m0_v;
            n_held   = m0;
        end else begin
            n_held_v = m1_v;
            n_held   = m1;
        end
    end

    assign o_res_valid = i_go && (r_held_v || m0_v);
    assign o_res       = r_held_v ? r_held : m0;

    assign o_wr.en   = i_go && (w_phase == PH_HEADER);
    assign o_wr.pos  = w_pos[5:0];
    assign o_wr.data = i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pos    <= '0;
            r_srow   <= '0;
            r_col    <= '0;
            r_bip    <= '0;
            r_bir    <= '0;
            r_held_v <= 1'b0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_srow   <= n_srow;
            r_col    <= n_col;
            r_bip    <= n_bip;
            r_bir    <= n_bir;
            r_held_v <= n_held_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_blue  <= n_blue;
            r_green <= n_green;
            r_held  <= n_held;
        end
    end

endmodule

/* hdl/bmp_stream_to_rgb565.sv */
// bmp_stream_to_rgb565: top level, bmp byte stream in, rgb565 pixel and status stream out
// depends on bmprgb_pkg, bmprgb_hdr and bmprgb_walk
//
// channel | direction | handshake              | payload
// --------+-----------+------------------------+--------------------------------------------
// in      | input     | i_in_valid / o_in_stall | i_data_byte, i_first_byte, i_last_byte
// out     | output    | o_out_valid / i_out_stall | o_kind, o_pixel_rgb565, o_col, o_row,
//         |           |                        | o_image_width, o_image_height, o_error_code
//
// one byte per clock while the output does not stall: each byte is parsed in a single pass
// between the input register and the result register
// a byte gives zero or one result; a byte that would give two hands one out now and
// keeps the other in a one-entry hold that drains with the next byte
// i_rst_n is synchronous and active low; it empties both registers and the hold
// an output stall holds the result register and stalls the input register in the same
// cycle, so no transaction is lost and the input side keeps one byte in flight
module bmp_stream_to_rgb565 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_pixel_rgb565,
    output logic [9:0]  o_col,
    output logic [9:0]  o_row,
    output logic [10:0] o_image_width,
    output logic [10:0] o_image_height,
    output logic [2:0]  o_error_code
);

    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int HB  = $clog2(MAX_HEIGHT + 1);
    localparam int RBB = $clog2(4 * MAX_WIDTH + 1);

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_first;
    logic       r_last;

    // result register
    logic                r_out_valid;
    bmprgb_pkg::t_result r_out;

    logic w_out_free;   // result register can take a result this cycle
    logic w_go;         // byte in the input register is parsed this cycle

    bmprgb_pkg::t_hdr_wr   w_wr;
    bmprgb_pkg::t_hdr_stat w_stat;
    logic [31:0]           w_offset;
    logic [WB-1:0]         w_width;
    logic [HB-1:0]         w_height;
    logic [RBB-1:0]        w_row_bytes;
    logic                  w_res_valid;
    bmprgb_pkg::t_result   w_res;

    // a byte is parsed whenever the result register is empty or being emptied
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_go       = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_byte  <= i_data_byte;
            r_first <= i_first_byte;
            r_last  <= i_last_byte;
        end
    end

    // header fields and checks
    bmprgb_hdr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_hdr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_wr),
        .o_stat      (w_stat),
        .o_offset    (w_offset),
        .o_width     (w_width),
        .o_height    (w_height),
        .o_row_bytes (w_row_bytes)
    );

    // parse sequencer and pixel packing
    bmprgb_walk #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_byte      (r_byte),
        .i_first     (r_first),
        .i_last      (r_last),
        .i_stat      (w_stat),
        .i_offset    (w_offset),
        .i_width     (w_width),
        .i_height    (w_height),
        .i_row_bytes (w_row_bytes),
        .o_wr        (w_wr),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register: loads a new result or drops the one just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_pixel_rgb565 = r_out.pix;
    assign o_col          = r_out.col;
    assign o_row          = r_out.row;
    assign o_image_width  = r_out.width;
    assign o_image_height = r_out.height;
    assign o_error_code   = r_out.err;

    // error code is set exactly on error transactions
    a_err_code_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_kind == bmprgb_pkg::KIND_ERROR)
                         == (o_error_code != bmprgb_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    // error transactions carry no size and no pixel
    a_err_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == bmprgb_pkg::KIND_ERROR)
        |-> (o_image_width == 11'd0 && o_image_height == 11'd0 && o_pixel_rgb565 == 16'd0))
        else $error("error transaction carries size or pixel data");

    // every pixel lands inside the accepted image
    a_pix_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == bmprgb_pkg::KIND_PIXEL
         && MAX_WIDTH <= 1024 && MAX_HEIGHT <= 1024)
        |-> (11'(o_col) < o_image_width && 11'(o_row) < o_image_height))
        else $error("pixel position outside the image");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking testbench for bmp_stream_to_rgb565, streams bmp files byte by byte
// depends on bmprgb_pkg (result kinds, error codes, header constants) and the rtl top level
module tb;
    import bmprgb_pkg::*;

    localparam int IMG_MAX_W     = 1024;
    localparam int IMG_MAX_H     = 1024;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_BYTES   = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 25;

    // parser phases of the local copy of the block
    typedef enum logic [2:0] {
        PS_IDLE,
        PS_HEADER,
        PS_SKIP,
        PS_PIXELS,
        PS_DONE,
        PS_ERROR
    } parse_phase_t;

    // one file to stream: header fields, how it ends, and the typed header outcome
    typedef struct packed {
        logic [15:0] sig;
        logic [31:0] comp;
        logic [15:0] depth;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] offset;
        int          cut;        // index of the final byte sent, -1 for the whole file
        bit          cut_last;   // mark the cut byte as end of file
        int          trail;      // bytes after the pixel area
        int          lead;       // loose bytes before the first byte
        bit          typed;      // header outcome below is checked as typed
        t_kind       want_kind;
        t_err        want_err;
    } bmp_file_t;

    // directed files: header checks in priority order, size extremes, every way a file ends
    localparam bmp_file_t DIRECTED_FILES [DIRECTED_ROWS] = '{
        // loose bytes while idle, then a bottom-up file with row padding and trailing bytes
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd3, 32'd2, 32'd54, -1, 1'b1, 2, 3,
          1'b1, KIND_HDR_OK, ERR_NONE},
        // bad signature wins over bad compression
        '{16'h4D43, 32'd5, DEPTH_24, 32'd2, 32'd2, 32'd54, -1, 1'b1, 0, 1,
          1'b1, KIND_ERROR, ERR_SIGNATURE},
        // compression wins over depth
        '{BMP_MAGIC, 32'd3, 16'd16, 32'd2, 32'd2, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_ERROR, ERR_COMPRESSED},
        '{BMP_MAGIC, 32'd0, 16'd16, 32'd2, 32'd2, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_ERROR, ERR_DEPTH},
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd0, 32'd2, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_ERROR, ERR_SIZE},
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd1025, 32'd2, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_ERROR, ERR_SIZE},
        // negative width
        '{BMP_MAGIC, 32'd0, DEPTH_32, 32'hFFFF_FFFF, 32'd2, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_ERROR, ERR_SIZE},
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd2, 32'd0, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_ERROR, ERR_SIZE},
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd2, 32'd1025, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_ERROR, ERR_SIZE},
        // height -1025 and the most negative height
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd2, 32'hFFFF_FBFF, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_ERROR, ERR_SIZE},
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd2, 32'h8000_0000, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_ERROR, ERR_SIZE},
        // pixel offset inside the header
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd2, 32'd2, 32'd53, -1, 1'b1, 0, 0,
          1'b1, KIND_ERROR, ERR_OFFSET},
        '{BMP_MAGIC, 32'd0, DEPTH_32, 32'd2, 32'd2, 32'd0, -1, 1'b1, 0, 0,
          1'b1, KIND_ERROR, ERR_OFFSET},
        // widest row, last pixel byte also completes the image
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd1024, 32'd1, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_HDR_OK, ERR_NONE},
        // tallest top-down image
        '{BMP_MAGIC, 32'd0, DEPTH_32, 32'd1, 32'hFFFF_FC00, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_HDR_OK, ERR_NONE},
        '{BMP_MAGIC, 32'd0, DEPTH_32, 32'd1024, 32'hFFFF_FFFF, 32'd60, -1, 1'b1, 0, 0,
          1'b1, KIND_HDR_OK, ERR_NONE},
        '{BMP_MAGIC, 32'd0, DEPTH_32, 32'd2, 32'hFFFF_FFFD, 32'd70, -1, 1'b1, 1, 0,
          1'b1, KIND_HDR_OK, ERR_NONE},
        // file ends inside the header
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd2, 32'd2, 32'd54, 20, 1'b1, 0, 0,
          1'b0, KIND_HDR_OK, ERR_NONE},
        // file ends on the last header byte: accepted, then truncated on the same byte
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd2, 32'd2, 32'd54, 53, 1'b1, 0, 0,
          1'b1, KIND_HDR_OK, ERR_NONE},
        // file ends in the skip area
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd2, 32'd2, 32'd100, 80, 1'b1, 0, 0,
          1'b1, KIND_HDR_OK, ERR_NONE},
        // offset at the top of its range
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd2, 32'd2, 32'hFFFF_FFFF, 70, 1'b1, 0, 0,
          1'b1, KIND_HDR_OK, ERR_NONE},
        // file ends in the row padding of the first stored row
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd2, 32'd2, 32'd54, 60, 1'b1, 0, 0,
          1'b1, KIND_HDR_OK, ERR_NONE},
        // abandoned mid file, the next first byte restarts the parse
        '{BMP_MAGIC, 32'd0, DEPTH_32, 32'd2, 32'd2, 32'd56, 65, 1'b0, 0, 0,
          1'b1, KIND_HDR_OK, ERR_NONE},
        // no row padding, end of file on the pixel that completes the image
        '{BMP_MAGIC, 32'd0, DEPTH_24, 32'd4, 32'd1, 32'd54, -1, 1'b1, 0, 0,
          1'b1, KIND_HDR_OK, ERR_NONE},
        // loose bytes before and after a finished image
        '{BMP_MAGIC, 32'd0, DEPTH_32, 32'd1, 32'd1, 32'd54, -1, 1'b1, 5, 2,
          1'b1, KIND_HDR_OK, ERR_NONE}
    };

    // clock, reset and ports
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_data_byte    = 8'd0;
    logic        i_first_byte   = 1'b0;
    logic        i_last_byte    = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [15:0] o_pixel_rgb565;
    logic [9:0]  o_col;
    logic [9:0]  o_row;
    logic [10:0] o_image_width;
    logic [10:0] o_image_height;
    logic [2:0]  o_error_code;

    // idle rates in percent, changed per phase by the stimulus process
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;
    int unsigned fault_count    = 0;

    // parse results still owed by the block, oldest first
    t_result parse_results_due [$];

    // local copy of the parser state
    parse_phase_t ps          = PS_IDLE;
    logic [31:0]  fpos        = '0;
    logic [15:0]  sig_word    = '0;
    logic [31:0]  pix_off     = '0;
    logic [31:0]  raw_w       = '0;
    logic [31:0]  raw_h       = '0;
    logic [15:0]  depth_bits  = '0;
    logic [31:0]  comp_code   = '0;
    int unsigned  src_row     = 0;
    int unsigned  col_cnt     = 0;
    int unsigned  byte_px     = 0;
    int unsigned  byte_row    = 0;
    logic [7:0]   blue_q      = '0;
    logic [7:0]   green_q     = '0;
    bit           hold_full   = 1'b0;
    t_result      hold_res    = '0;
    t_result      step_results [$];

    bmp_stream_to_rgb565 #(
        .MAX_WIDTH (IMG_MAX_W),
        .MAX_HEIGHT(IMG_MAX_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_first_byte  (i_first_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_pixel_rgb565(o_pixel_rgb565),
        .o_col         (o_col),
        .o_row         (o_row),
        .o_image_width (o_image_width),
        .o_image_height(o_image_height),
        .o_error_code  (o_error_code)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // parser copy
    // ------------------------------------------------------------------

    function automatic logic [31:0] abs_height();
        return raw_h[31] ? 32'd0 - raw_h : raw_h;
    endfunction

    // collect one result of the current byte; a byte gives at most two
    task automatic add_result(input t_kind k, input t_err e, input logic [15:0] pix,
                              input logic [9:0] c, input logic [9:0] r);
        t_result     res;
        logic [31:0] ah;
        ah         = abs_height();
        res        = '0;
        res.kind   = k;
        res.err    = e;
        res.pix    = pix;
        res.col    = c;
        res.row    = r;
        res.width  = (k == KIND_ERROR) ? 11'd0 : raw_w[10:0];
        res.height = (k == KIND_ERROR) ? 11'd0 : ah[10:0];
        if (step_results.size() < 2) begin
            step_results.push_back(res);
        end
    endtask

    task automatic abort_file(input t_err e);
        ps = PS_ERROR;
        add_result(KIND_ERROR, e, 16'd0, 10'd0, 10'd0);
    endtask

    // one byte of the pixel area: gather b,g,r, skip alpha and padding, count rows
    task automatic walk_pixel(input logic [7:0] b, input bit l);
        int unsigned bpp;
        logic [31:0] ah;
        logic [31:0] rbytes;
        logic [31:0] out_row;
        bit          finished;
        bpp      = depth_bits / 8;
        ah       = abs_height();
        rbytes   = (bpp * raw_w + 32'd3) & ~32'd3;
        finished = 1'b0;
        if (col_cnt < raw_w) begin
            case (byte_px)
                0: blue_q = b;
                1: green_q = b;
                2: begin
                    // bottom-up files are flipped so the first stored row gets the bottom output row
                    out_row = raw_h[31] ? src_row : ah - 32'd1 - src_row;
                    add_result(KIND_PIXEL, ERR_NONE, {b[7:3], green_q[7:2], blue_q[7:3]},
                               col_cnt[9:0], out_row[9:0]);
                end
                default: ;
            endcase
            byte_px++;
            if (byte_px >= bpp) begin
                byte_px = 0;
                col_cnt++;
            end
        end
        byte_row++;
        if (byte_row >= rbytes) begin
            byte_row = 0;
            col_cnt  = 0;
            byte_px  = 0;
            src_row++;
            if (src_row >= ah) begin
                ps = PS_DONE;
                add_result(KIND_DONE, ERR_NONE, 16'd0, 10'd0, 10'd0);
                finished = 1'b1;
            end
        end
        if (l && !finished) begin
            abort_file(ERR_TRUNCATED);
        end
    endtask

    // advance the parser copy by one accepted byte and queue what the block owes;
    // use_typed swaps the header outcome for the one typed in the table
    task automatic parse_byte(input logic [7:0] b, input bit f, input bit l,
                              input bit use_typed, input t_result typed_res);
        int          p;
        logic [31:0] ah;
        t_err        e;
        step_results.delete();
        if (f) begin
            ps       = PS_HEADER;
            fpos     = '0;
            src_row  = 0;
            col_cnt  = 0;
            byte_px  = 0;
            byte_row = 0;
        end
        p = fpos[5:0];
        case (ps)
            PS_HEADER: begin
                // little-endian header fields
                if (p < 2) begin
                    sig_word[8*p +: 8] = b;
                end else if (p >= 10 && p < 14) begin
                    pix_off[8*(p-10) +: 8] = b;
                end else if (p >= 18 && p < 22) begin
                    raw_w[8*(p-18) +: 8] = b;
                end else if (p >= 22 && p < 26) begin
                    raw_h[8*(p-22) +: 8] = b;
                end else if (p >= 28 && p < 30) begin
                    depth_bits[8*(p-28) +: 8] = b;
                end else if (p >= 30 && p < 34) begin
                    comp_code[8*(p-30) +: 8] = b;
                end
                if (fpos == LAST_HDR_POS) begin
                    ah = abs_height();
                    // first failing check is the one reported
                    if (sig_word != BMP_MAGIC) begin
                        e = ERR_SIGNATURE;
                    end else if (comp_code != 32'd0) begin
                        e = ERR_COMPRESSED;
                    end else if (depth_bits != DEPTH_24 && depth_bits != DEPTH_32) begin
                        e = ERR_DEPTH;
                    end else if (raw_w == 32'd0 || raw_w[31] || raw_w > IMG_MAX_W) begin
                        e = ERR_SIZE;
                    end else if (ah == 32'd0 || ah > IMG_MAX_H) begin
                        e = ERR_SIZE;
                    end else if (pix_off < HDR_BYTES) begin
                        e = ERR_OFFSET;
                    end else begin
                        e = ERR_NONE;
                    end
                    if (e != ERR_NONE) begin
                        abort_file(e);
                    end else begin
                        ps = (pix_off == HDR_BYTES) ? PS_PIXELS : PS_SKIP;
                        add_result(KIND_HDR_OK, ERR_NONE, 16'd0, 10'd0, 10'd0);
                        if (l) begin
                            abort_file(ERR_TRUNCATED);
                        end
                    end
                end else if (l) begin
                    abort_file(ERR_TRUNCATED);
                end
            end
            PS_SKIP: begin
                if (fpos == pix_off) begin
                    ps = PS_PIXELS;
                    walk_pixel(b, l);
                end else if (l) begin
                    abort_file(ERR_TRUNCATED);
                end
            end
            PS_PIXELS: walk_pixel(b, l);
            default: ;
        endcase
        // byte position saturates
        if (ps != PS_IDLE && fpos != 32'hFFFF_FFFF) begin
            fpos++;
        end
        // a held result goes out first and the new one waits in its place
        if (hold_full) begin
            parse_results_due.push_back(hold_res);
            hold_full = step_results.size() > 0;
            if (hold_full) begin
                hold_res = step_results[0];
            end
        end else if (step_results.size() > 0) begin
            parse_results_due.push_back(use_typed ? typed_res : step_results[0]);
            hold_full = step_results.size() > 1;
            if (hold_full) begin
                hold_res = step_results[1];
            end
        end
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offer one byte after a random gap, hold it until the transaction happens
    task automatic push_byte(input logic [7:0] b, input bit f, input bit l,
                             input bit use_typed, input t_result typed_res);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_first_byte <= f;
        i_last_byte  <= l;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        parse_byte(b, f, l, use_typed, typed_res);
    endtask

    // stream one file: loose bytes, header, skip area, pixel rows, trailing bytes
    task automatic send_file(input bmp_file_t fd, output int sent);
        longint      skip_to;
        longint      pix_len;
        longint      full_len;
        longint      n;
        longint      pos;
        logic [31:0] ah;
        logic [31:0] rb;
        logic [7:0]  b;
        bit          is_last;
        bit          sane;
        int          p;
        int          i;
        t_result     typed_res;
        ah   = fd.height[31] ? 32'd0 - fd.height : fd.height;
        rb   = ((fd.depth / 8) * fd.width + 32'd3) & ~32'd3;
        sane = (fd.depth == DEPTH_24 || fd.depth == DEPTH_32) && fd.width != 32'd0 &&
               fd.width <= IMG_MAX_W && ah != 32'd0 && ah <= IMG_MAX_H;
        // pixel rows only where the sizes make sense, else just header and trail
        skip_to  = (fd.offset < HDR_BYTES || !sane) ? longint'(HDR_BYTES) : longint'(fd.offset);
        pix_len  = sane ? longint'(ah) * longint'(rb) : 0;
        full_len = skip_to + pix_len + fd.trail;
        n        = (fd.cut >= 0 && fd.cut < full_len) ? fd.cut + 1 : full_len;
        typed_res      = '0;
        typed_res.kind = fd.want_kind;
        typed_res.err  = fd.want_err;
        if (fd.want_kind != KIND_ERROR) begin
            typed_res.width  = fd.width[10:0];
            typed_res.height = ah[10:0];
        end
        for (i = 0; i < fd.lead; i++) begin
            push_byte($urandom, 1'b0, $urandom_range(1), 1'b0, typed_res);
        end
        for (pos = 0; pos < n; pos++) begin
            p = int'(pos < 64 ? pos : 64);
            b = $urandom;
            if (p < 2) begin
                b = fd.sig[8*p +: 8];
            end else if (p >= 10 && p < 14) begin
                b = fd.offset[8*(p-10) +: 8];
            end else if (p >= 18 && p < 22) begin
                b = fd.width[8*(p-18) +: 8];
            end else if (p >= 22 && p < 26) begin
                b = fd.height[8*(p-22) +: 8];
            end else if (p >= 28 && p < 30) begin
                b = fd.depth[8*(p-28) +: 8];
            end else if (p >= 30 && p < 34) begin
                b = fd.comp[8*(p-30) +: 8];
            end
            is_last = (pos == n - 1) && (n == full_len || fd.cut_last);
            push_byte(b, pos == 0, is_last, fd.typed && pos == 53, typed_res);
        end
        sent = int'(n);
    endtask

    // ------------------------------------------------------------------
    // output side: random stall, each transaction against the oldest owed result
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (parse_results_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("mismatch: unexpected result kind %0d err %0d at cycle %0d",
                                 o_kind, o_error_code, cycle_count);
                    end
                end else begin
                    want = parse_results_due.pop_front();
                    if (o_kind !== want.kind || o_pixel_rgb565 !== want.pix ||
                        o_col !== want.col || o_row !== want.row ||
                        o_image_width !== want.width || o_image_height !== want.height ||
                        o_error_code !== want.err) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT) begin
                            $display({"mismatch at cycle %0d (exp/got): kind %0d/%0d ",
                                      "pix %h/%h col %0d/%0d row %0d/%0d w %0d/%0d ",
                                      "h %0d/%0d err %0d/%0d"},
                                     cycle_count, want.kind, o_kind, want.pix,
                                     o_pixel_rgb565, want.col, o_col, want.row, o_row,
                                     want.width, o_image_width, want.height,
                                     o_image_height, want.err, o_error_code);
                        end
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus: directed files, then three random phases with shifting idle rates
    // ------------------------------------------------------------------

    initial begin : stimulus
        bmp_file_t   fd;
        int          phase_idx;
        int          row_idx;
        int          phase_bytes;
        int          sent;
        logic [31:0] h;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (phase_idx = 0; phase_idx < 3; phase_idx++) begin
            // sender busy / receiver slow, then the reverse, then full rate
            case (phase_idx)
                0: begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 46;
                end
                1: begin
                    send_idle_pct  = 46;
                    recv_stall_pct = 24;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            if (phase_idx == 0) begin
                for (row_idx = 0; row_idx < DIRECTED_ROWS; row_idx++) begin
                    send_file(DIRECTED_FILES[row_idx], sent);
                end
            end

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                // mostly well-formed small files with random pixels
                fd.sig      = BMP_MAGIC;
                fd.comp     = 32'd0;
                fd.depth    = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
                fd.width    = ($urandom_range(7) == 0) ? $urandom_range(1, 40)
                                                       : $urandom_range(1, 5);
                h           = $urandom_range(1, 4);
                fd.height   = $urandom_range(1) ? h : 32'd0 - h;
                fd.offset   = $urandom_range(1) ? HDR_BYTES : HDR_BYTES + $urandom_range(1, 8);
                fd.cut      = -1;
                fd.cut_last = 1'b1;
                fd.trail    = $urandom_range(2) ? 0 : $urandom_range(1, 4);
                fd.lead     = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
                fd.typed    = 1'b0;
                fd.want_kind = KIND_HDR_OK;
                fd.want_err  = ERR_NONE;
                // the rest: one broken field, an early end or an abandoned file
                case ($urandom_range(15))
                    0: begin
                        fd.sig = $urandom;
                        if (fd.sig == BMP_MAGIC) fd.sig = 16'd0;
                    end
                    1: begin
                        fd.comp = $urandom;
                        if (fd.comp == 32'd0) fd.comp = 32'd1;
                    end
                    2: begin
                        fd.depth = $urandom;
                        if (fd.depth == DEPTH_24 || fd.depth == DEPTH_32) fd.depth = 16'd0;
                    end
                    3: begin
                        case ($urandom_range(2))
                            0: fd.width = 32'd0;
                            1: fd.width = IMG_MAX_W + $urandom_range(1, 3000);
                            default: fd.width = $urandom | 32'h8000_0000;
                        endcase
                    end
                    4: begin
                        case ($urandom_range(3))
                            0: fd.height = 32'd0;
                            1: fd.height = IMG_MAX_H + $urandom_range(1, 3000);
                            2: fd.height = 32'd0 - (IMG_MAX_H + $urandom_range(1, 3000));
                            default: fd.height = 32'h8000_0000;
                        endcase
                    end
                    5: fd.offset = $urandom_range(53);
                    6, 7: fd.cut = $urandom_range(0, 150);
                    8: begin
                        fd.cut      = $urandom_range(0, 150);
                        fd.cut_last = 1'b0;
                    end
                    default: ;
                endcase
                send_file(fd, sent);
                phase_bytes += sent;
            end

            // sender holds off until the block has handed over everything it owes
            i_in_valid <= 1'b0;
            while (parse_results_due.size() != 0) begin
                @(posedge i_clk);
            end
            repeat (10) @(posedge i_clk);
        end

        if (fault_count == 0 && parse_results_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("tb: done, errors");
        $finish;
    end

endmodule

/* bmp_stream_to_rgb565.f */
hdl/bmprgb_pkg.sv
hdl/bmprgb_hdr.sv
hdl/bmprgb_walk.sv
hdl/bmp_stream_to_rgb565.sv
tb/tb.sv
